>>> rtl/core/blrc_pkg.sv
// Shared types, codes and constants of the block receiver with LRC and ACK/NAK.
package blrc_pkg;

  // Field widths.
  localparam int unsigned CountW  = 15;
  localparam int unsigned RetryW  = 3;
  localparam int unsigned ActionW = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ErrW    = 3;

  // Default number of data bytes in a full block.
  localparam int unsigned BlockSizeDef = 128;

  // Register reset values.
  localparam logic [CountW-1:0] ByteCountRst  = CountW'(1);
  localparam logic [RetryW-1:0] RetryLimitRst = RetryW'(3);

  // Control characters on the serial link.
  localparam logic [ByteW-1:0] ChStx = 8'h02;
  localparam logic [ByteW-1:0] ChEtb = 8'h17;
  localparam logic [ByteW-1:0] ChEtx = 8'h03;
  localparam logic [ByteW-1:0] ChEot = 8'h04;
  localparam logic [ByteW-1:0] ChAck = 8'h06;
  localparam logic [ByteW-1:0] ChNak = 8'h15;

  // Input action codes.
  localparam logic [ActionW-1:0] ActStart   = 2'd0;
  localparam logic [ActionW-1:0] ActByte    = 2'd1;
  localparam logic [ActionW-1:0] ActTimeout = 2'd2;

  // Completion codes.
  localparam logic [ErrW-1:0] ErrNone    = 3'd0;
  localparam logic [ErrW-1:0] ErrTimeout = 3'd1;
  localparam logic [ErrW-1:0] ErrNoStx   = 3'd2;
  localparam logic [ErrW-1:0] ErrNoEtb   = 3'd3;
  localparam logic [ErrW-1:0] ErrNoEtx   = 3'd4;
  localparam logic [ErrW-1:0] ErrRetry   = 3'd5;
  localparam logic [ErrW-1:0] ErrNoEot   = 3'd6;

  // Register indexes on the configuration port.
  localparam logic RegByteCount  = 1'b0;
  localparam logic RegRetryLimit = 1'b1;

  // Receive phase.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STX  = 3'd1,
    PH_DATA = 3'd2,
    PH_END  = 3'd3,
    PH_LRC  = 3'd4,
    PH_EOT  = 3'd5
  } phase_e;

  // Configuration handed to the receive engine. The block layout is derived
  // from the byte count when that register is written.
  typedef struct packed {
    logic [CountW-1:0] lead_blocks;  // number of blocks before the last one
    logic [ByteW-1:0]  last_len;     // data bytes in the last block
    logic [RetryW-1:0] retry_limit;
  } cfg_t;

  // One input word.
  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [ByteW-1:0]   rx_byte;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic              tx_valid;
    logic [ByteW-1:0]  tx_byte;
    logic              data_valid;
    logic [CountW-1:0] data_addr;
    logic [ByteW-1:0]  data_byte;
    logic              done_res;
    logic [ErrW-1:0]   error_code;
    logic              busy_res;
  } out_word_t;

endpackage

>>> rtl/core/blrc_if.sv
// Valid/ready channel interfaces for the input and result words.
interface blrc_in_if
  import blrc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [ByteW-1:0]   rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink (input valid, action, rx_byte, output ready);
endinterface

interface blrc_out_if
  import blrc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              tx_valid;
  logic [ByteW-1:0]  tx_byte;
  logic              data_valid;
  logic [CountW-1:0] data_addr;
  logic [ByteW-1:0]  data_byte;
  logic              done_res;
  logic [ErrW-1:0]   error_code;
  logic              busy_res;

  modport source (output valid, tx_valid, tx_byte, data_valid, data_addr, data_byte,
                  done_res, error_code, busy_res, input ready);
  modport sink (input valid, tx_valid, tx_byte, data_valid, data_addr, data_byte,
                done_res, error_code, busy_res, output ready);
endinterface

>>> rtl/core/block_receiver_lrc_ack_nak.sv
// Block receiver with LRC check and ACK/NAK reply: top level.
//
// Input channel in_i carries one word per event on the serial side: a start
// of transfer, a received byte, or a receive timeout. Result channel out_o
// returns exactly one word per input word: an optional reply byte to send
// (ACK, NAK or EOT), an optional payload write (offset and byte), a done flag
// with its completion code, and whether a transfer is still in progress.
// Both channels use valid/ready; a word moves when both are high.
//
// Each word is handled in a single pass through the receive state machine
// and lands in the result register, so the result appears in the cycle after the
// input word is taken. One word per cycle is sustained while out_o is ready.
// A stalled receiver holds its result; no further input word is taken
// until the held result leaves the register.
//
// The APB port sets the byte count (offset 0) and the retry limit (offset 4);
// write them only while no word is in flight. A new byte count moves the
// block bounds of a running transfer at once. Reset returns the receiver
// to idle with a byte count of one and a retry limit of three.
module block_receiver_lrc_ack_nak
  import blrc_pkg::*;
#(
  parameter int unsigned BLOCK_SIZE = BlockSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  blrc_in_if.sink     in_i,
  blrc_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  in_word_t  in_word;
  out_word_t out_word;
  logic      in_ready;
  logic      out_valid;

  // Configuration registers.
  blrc_cfg #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Channel payload to and from the engine.
  assign in_word.action  = in_i.action;
  assign in_word.rx_byte = in_i.rx_byte;
  assign in_i.ready      = in_ready;

  assign out_o.valid      = out_valid;
  assign out_o.tx_valid   = out_word.tx_valid;
  assign out_o.tx_byte    = out_word.tx_byte;
  assign out_o.data_valid = out_word.data_valid;
  assign out_o.data_addr  = out_word.data_addr;
  assign out_o.data_byte  = out_word.data_byte;
  assign out_o.done_res   = out_word.done_res;
  assign out_o.error_code = out_word.error_code;
  assign out_o.busy_res   = out_word.busy_res;

  // Receive engine.
  blrc_fsm #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_word)
  );

endmodule

>>> rtl/core/blrc_cfg.sv
// APB-style configuration registers: byte count and retry limit.
module blrc_cfg
  import blrc_pkg::*;
#(
  parameter int unsigned BLOCK_SIZE = BlockSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  // Division by the block size is done as a multiplication by its reciprocal.
  // With counts below 2^15 and a block size below 2^8 a shift of 23 is exact.
  localparam int unsigned     RecipS  = 23;
  localparam int unsigned     RecipW  = 24;
  localparam logic [RecipW-1:0] RecipM =
    RecipW'(((2 ** RecipS) + BLOCK_SIZE - 1) / BLOCK_SIZE);
  localparam logic [CountW-1:0] BlkSize = CountW'(BLOCK_SIZE);

  logic [CountW-1:0]        byte_count_q;
  logic [RetryW-1:0]        retry_limit_q;
  logic [CountW-1:0]        lead_q, lead_d;
  logic [ByteW-1:0]         last_len_q, last_len_d;
  logic                     wr_en;
  logic                     reg_sel;
  logic [CountW-1:0]        wr_count;
  logic [CountW-1:0]        count_m1;
  logic [CountW+RecipW-1:0] lead_prod;
  logic [CountW-1:0]        lead_base;
  logic [CountW-1:0]        last_rem;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  // Block layout of the written count; a zero count acts as one byte.
  assign wr_count   = pwdata[CountW-1:0];
  assign count_m1   = (wr_count == '0) ? '0 : wr_count - CountW'(1);
  assign lead_prod  = (CountW+RecipW)'(count_m1) * (CountW+RecipW)'(RecipM);
  assign lead_d     = lead_prod[RecipS +: CountW];
  assign lead_base  = lead_d * BlkSize;
  assign last_rem   = count_m1 - lead_base;
  assign last_len_d = last_rem[ByteW-1:0] + ByteW'(1);

  // Register writes in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= ByteCountRst;
      retry_limit_q <= RetryLimitRst;
      lead_q        <= '0;
      last_len_q    <= ByteW'(1);
    end else if (wr_en) begin
      unique case (reg_sel)
        RegByteCount: begin
          byte_count_q <= wr_count;
          lead_q       <= lead_d;
          last_len_q   <= last_len_d;
        end
        RegRetryLimit: retry_limit_q <= pwdata[RetryW-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_sel)
      RegByteCount:  prdata = {{(32-CountW){1'b0}}, byte_count_q};
      RegRetryLimit: prdata = {{(32-RetryW){1'b0}}, retry_limit_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.lead_blocks = lead_q;
  assign cfg_o.last_len    = last_len_q;
  assign cfg_o.retry_limit = retry_limit_q;

endmodule

>>> rtl/core/blrc_fsm.sv
// Receive engine: framing state machine, LRC check and the result register.
module blrc_fsm
  import blrc_pkg::*;
#(
  parameter int unsigned BLOCK_SIZE = BlockSizeDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam logic [CountW-1:0] BlkSize = CountW'(BLOCK_SIZE);
  localparam logic [ByteW-1:0]  BlkLen  = ByteW'(BLOCK_SIZE);

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] blk_q, blk_d;      // index of the current block
  logic [CountW-1:0] base_q, base_d;    // offset of the first byte of this block
  logic [ByteW-1:0]  bib_q, bib_d;      // bytes received in this block
  logic [ByteW-1:0]  lrc_q, lrc_d;
  logic [RetryW-1:0] retry_q, retry_d;
  logic              out_valid_q;
  out_word_t         res_q, res_d;

  logic              accept;
  logic              last_blk;
  logic [ByteW-1:0]  blk_len;
  logic [ByteW-1:0]  bib_inc;

  // A new word is taken whenever the result register is free or being emptied.
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = res_q;

  // Block bounds follow the byte count register as it stands now.
  assign last_blk = (blk_q >= cfg_i.lead_blocks);
  assign blk_len  = last_blk ? cfg_i.last_len : BlkLen;
  assign bib_inc  = bib_q + ByteW'(1);

  // Next state and result for the accepted word.
  always_comb begin
    phase_d = phase_q;
    blk_d   = blk_q;
    base_d  = base_q;
    bib_d   = bib_q;
    lrc_d   = lrc_q;
    retry_d = retry_q;
    res_d   = '0;

    case (in_word_i.action)
      ActStart: begin
        phase_d = PH_STX;
        blk_d   = '0;
        base_d  = '0;
        bib_d   = '0;
        lrc_d   = '0;
        retry_d = '0;
      end
      ActTimeout: begin
        if (phase_q != PH_IDLE) begin
          phase_d        = PH_IDLE;
          res_d.done_res = 1'b1;
          if (phase_q == PH_EOT) begin
            res_d.tx_valid   = 1'b1;
            res_d.tx_byte    = ChEot;
            res_d.error_code = ErrNoEot;
          end else begin
            res_d.error_code = ErrTimeout;
          end
        end
      end
      ActByte: begin
        unique case (phase_q)
          PH_IDLE: ;
          PH_STX: begin
            if (in_word_i.rx_byte == ChStx) begin
              bib_d   = '0;
              lrc_d   = '0;
              phase_d = PH_DATA;
            end else begin
              phase_d          = PH_IDLE;
              res_d.done_res   = 1'b1;
              res_d.error_code = ErrNoStx;
            end
          end
          PH_DATA: begin
            res_d.data_valid = 1'b1;
            res_d.data_addr  = base_q + {{(CountW-ByteW){1'b0}}, bib_q};
            res_d.data_byte  = in_word_i.rx_byte;
            lrc_d            = lrc_q + in_word_i.rx_byte;
            bib_d            = bib_inc;
            if ((bib_inc >= blk_len) || (bib_inc == '0)) begin
              phase_d = PH_END;
            end
          end
          PH_END: begin
            if (last_blk ? (in_word_i.rx_byte == ChEtx) : (in_word_i.rx_byte == ChEtb)) begin
              phase_d = PH_LRC;
            end else begin
              phase_d          = PH_IDLE;
              res_d.done_res   = 1'b1;
              res_d.error_code = last_blk ? ErrNoEtx : ErrNoEtb;
            end
          end
          PH_LRC: begin
            res_d.tx_valid = 1'b1;
            if (in_word_i.rx_byte == lrc_q) begin
              res_d.tx_byte = ChAck;
              retry_d       = '0;
              if (last_blk) begin
                phase_d = PH_EOT;
              end else begin
                base_d  = base_q + BlkSize;
                blk_d   = blk_q + CountW'(1);
                phase_d = PH_STX;
              end
            end else begin
              res_d.tx_byte = ChNak;
              if (retry_q >= cfg_i.retry_limit) begin
                phase_d          = PH_IDLE;
                res_d.done_res   = 1'b1;
                res_d.error_code = ErrRetry;
              end else begin
                retry_d = retry_q + RetryW'(1);
                phase_d = PH_STX;
              end
            end
          end
          PH_EOT: begin
            phase_d          = PH_IDLE;
            res_d.tx_valid   = 1'b1;
            res_d.tx_byte    = ChEot;
            res_d.done_res   = 1'b1;
            res_d.error_code = (in_word_i.rx_byte == ChEot) ? ErrNone : ErrNoEot;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    res_d.busy_res = (phase_d != PH_IDLE);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      blk_q       <= '0;
      base_q      <= '0;
      bib_q       <= '0;
      lrc_q       <= '0;
      retry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        blk_q   <= blk_d;
        base_q  <= base_d;
        bib_q   <= bib_d;
        lrc_q   <= lrc_d;
        retry_q <= retry_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

endmodule

>>> bench/block_receiver_lrc_ack_nak_tb.sv
// Self-checking testbench for the block receiver with LRC check and ACK/NAK reply.
module block_receiver_lrc_ack_nak_tb
  import blrc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // The fourth action code has no meaning and must be ignored.
  localparam logic [ActionW-1:0] ActUnused = 2'd3;
  localparam int unsigned MaxShown = 10;

  // Tracks the receiver state and holds the results each accepted word should produce.
  class block_rx_predictor;
    logic [CountW-1:0] byte_count;
    logic [RetryW-1:0] retry_limit;
    phase_e            phase;
    logic [CountW-1:0] blk_num;
    logic [ByteW-1:0]  blk_pos;
    logic [ByteW-1:0]  lrc_sum;
    logic [RetryW-1:0] nak_count;
    logic [ErrW-1:0]   last_code;
    out_word_t         pred;
    out_word_t         due_responses[$];
    int unsigned       n_checked;
    int unsigned       n_bad;
    int unsigned       ends_by_code[8];

    function new();
      byte_count  = ByteCountRst;
      retry_limit = RetryLimitRst;
      phase       = PH_IDLE;
      blk_num     = '0;
      blk_pos     = '0;
      lrc_sum     = '0;
      nak_count   = '0;
      last_code   = ErrNone;
      n_checked   = 0;
      n_bad       = 0;
      foreach (ends_by_code[i]) ends_by_code[i] = 0;
    endfunction

    function void set_config(logic idx, logic [31:0] value);
      if (idx == RegByteCount) begin
        byte_count = value[CountW-1:0];
      end else begin
        retry_limit = value[RetryW-1:0];
      end
    endfunction

    // A count of zero behaves as a single byte.
    function int unsigned total_bytes();
      return (byte_count == 0) ? 1 : int'(byte_count);
    endfunction

    function int unsigned leading_blocks();
      return (total_bytes() - 1) / BlockSizeDef;
    endfunction

    function bit on_last_block();
      return blk_num >= leading_blocks();
    endfunction

    // Block bounds follow the register as it stands now.
    function int unsigned block_bytes();
      if (!on_last_block()) return BlockSizeDef;
      return total_bytes() - leading_blocks() * BlockSizeDef;
    endfunction

    function void end_transfer(logic [ErrW-1:0] code);
      last_code       = code;
      phase           = PH_IDLE;
      pred.done_res   = 1'b1;
      pred.error_code = code;
    endfunction

    // Advance the receiver by one accepted word and queue the result it causes.
    function void take_word(logic [ActionW-1:0] act, logic [ByteW-1:0] b);
      int unsigned offset;
      pred = '0;
      if (act == ActStart) begin
        phase     = PH_STX;
        blk_num   = '0;
        blk_pos   = '0;
        lrc_sum   = '0;
        nak_count = '0;
        last_code = ErrNone;
      end else if (act == ActTimeout && phase != PH_IDLE) begin
        // A timeout while waiting for the final EOT still answers with EOT.
        if (phase == PH_EOT) begin
          pred.tx_valid = 1'b1;
          pred.tx_byte  = ChEot;
          end_transfer(ErrNoEot);
        end else begin
          end_transfer(ErrTimeout);
        end
      end else if (act == ActByte) begin
        case (phase)
          PH_STX: begin
            if (b == ChStx) begin
              blk_pos = '0;
              lrc_sum = '0;
              phase   = PH_DATA;
            end else begin
              end_transfer(ErrNoStx);
            end
          end
          PH_DATA: begin
            offset          = blk_num * BlockSizeDef + blk_pos;
            pred.data_valid = 1'b1;
            pred.data_addr  = CountW'(offset);
            pred.data_byte  = b;
            lrc_sum         = lrc_sum + b;
            blk_pos         = blk_pos + 1'b1;
            if (blk_pos >= block_bytes() || blk_pos == 0) phase = PH_END;
          end
          PH_END: begin
            if (on_last_block()) begin
              if (b == ChEtx) phase = PH_LRC;
              else end_transfer(ErrNoEtx);
            end else begin
              if (b == ChEtb) phase = PH_LRC;
              else end_transfer(ErrNoEtb);
            end
          end
          PH_LRC: begin
            pred.tx_valid = 1'b1;
            if (b == lrc_sum) begin
              pred.tx_byte = ChAck;
              nak_count    = '0;
              if (on_last_block()) begin
                phase = PH_EOT;
              end else begin
                blk_num = blk_num + 1'b1;
                phase   = PH_STX;
              end
            end else begin
              // The NAK goes out even when the retries are used up.
              pred.tx_byte = ChNak;
              if (nak_count >= retry_limit) begin
                end_transfer(ErrRetry);
              end else begin
                nak_count = nak_count + 1'b1;
                phase     = PH_STX;
              end
            end
          end
          PH_EOT: begin
            pred.tx_valid = 1'b1;
            pred.tx_byte  = ChEot;
            end_transfer((b == ChEot) ? ErrNone : ErrNoEot);
          end
          default: ;
        endcase
      end
      pred.busy_res = (phase != PH_IDLE);
      due_responses.push_back(pred);
    endfunction

    function string show(out_word_t w);
      return $sformatf("tx=%0b/%02h wr=%0b@%0d:%02h done=%0b code=%0d busy=%0b",
                       w.tx_valid, w.tx_byte, w.data_valid, w.data_addr, w.data_byte,
                       w.done_res, w.error_code, w.busy_res);
    endfunction

    // Compare one result word with the oldest pending one, field by field.
    function void match_response(out_word_t got);
      out_word_t want;
      bit        same;
      if (due_responses.size() == 0) begin
        n_bad++;
        if (n_bad <= MaxShown) $display("%0t: result with none pending: %s", $time, show(got));
        return;
      end
      want = due_responses.pop_front();
      n_checked++;
      if (want.done_res) ends_by_code[want.error_code]++;
      same = (got.tx_valid === want.tx_valid) && (got.tx_byte === want.tx_byte) &&
             (got.data_valid === want.data_valid) && (got.data_addr === want.data_addr) &&
             (got.data_byte === want.data_byte) && (got.done_res === want.done_res) &&
             (got.error_code === want.error_code) && (got.busy_res === want.busy_res);
      if (!same) begin
        n_bad++;
        if (n_bad <= MaxShown) begin
          $display("%0t: mismatch, expected %s", $time, show(want));
          $display("%0t:           actual   %s", $time, show(got));
        end
      end
    endfunction

    function int unsigned pending();
      return due_responses.size();
    endfunction

    // Anything still pending at the end counts against the run.
    function int unsigned close_out();
      if (due_responses.size() != 0) begin
        $display("%0d expected results never arrived", due_responses.size());
        n_bad += due_responses.size();
      end
      return n_bad;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  blrc_in_if  in_if ();
  blrc_out_if out_if ();

  block_receiver_lrc_ack_nak i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  block_rx_predictor rx_pred = new();

  logic [CountW-1:0] cur_count = ByteCountRst;
  logic [RetryW-1:0] cur_retry = RetryLimitRst;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned n_items   = 0;
  int unsigned n_words   = 0;
  int unsigned n_cfg     = 0;
  int unsigned n_fail;
  int unsigned src_mix[4] = '{0, 85, 0, 11};
  int unsigned snk_mix[4] = '{0, 0, 85, 11};

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: ready changes at the falling edge, stalling at the current rate.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watch both channels at the rising edge; a new word is noted before results are checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) rx_pred.take_word(in_if.action, in_if.rx_byte);
      if (out_if.valid && out_if.ready) begin
        rx_pred.match_response(out_word_t'{out_if.tx_valid, out_if.tx_byte, out_if.data_valid,
                                           out_if.data_addr, out_if.data_byte, out_if.done_res,
                                           out_if.error_code, out_if.busy_res});
      end
    end
  end

  // Present one word, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_word(logic [ActionW-1:0] act, logic [ByteW-1:0] value, bit counted);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid   <= 1'b1;
    in_if.action  <= act;
    in_if.rx_byte <= value;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    n_words++;
    if (counted) n_items++;
  endtask

  // Stop sending and wait until every pending result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (rx_pred.pending() != 0) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic reg_write(logic idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rx_pred.set_config(idx, value);
    if (idx == RegByteCount) cur_count = value[CountW-1:0];
    else cur_retry = value[RetryW-1:0];
    n_cfg++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // New random settings, edge values weighted up.
  task automatic pick_config();
    logic [CountW-1:0] cnt;
    case ($urandom_range(9))
      0:       cnt = 1;
      1:       cnt = 128;
      2:       cnt = 129;
      3:       cnt = 256;
      4:       cnt = 0;
      default: cnt = CountW'($urandom_range(2, 200));
    endcase
    reg_write(RegRetryLimit, 32'($urandom_range(0, 7)));
    reg_write(RegByteCount, 32'(cnt));
  endtask

  // One transfer, mostly well formed; faults abort it now and then. A block index in
  // cut_block ends the transfer with a timeout where that block would start.
  task automatic run_transfer(int cut_block);
    int unsigned       total;
    int unsigned       size;
    int unsigned       naks;
    int unsigned       nak_pct;
    int                nblk;
    logic [ByteW-1:0]  sum;
    logic [ByteW-1:0]  b;
    logic [ByteW-1:0]  term;
    total   = (cur_count == 0) ? 1 : int'(cur_count);
    nblk    = (total - 1) / BlockSizeDef + 1;
    nak_pct = ($urandom_range(5) == 0) ? 80 : 12;
    send_word(ActStart, ByteW'($urandom), 1'b1);
    for (int blk = 0; blk < nblk; blk++) begin
      size = (blk == nblk - 1) ? total - (nblk - 1) * BlockSizeDef : BlockSizeDef;
      term = (blk == nblk - 1) ? ChEtx : ChEtb;
      naks = 0;
      forever begin
        if (blk == cut_block) begin
          send_word(ActTimeout, ByteW'($urandom), 1'b1);
          return;
        end
        // Rare faults where STX belongs: timeout, wrong byte, or a restart.
        case ($urandom_range(99))
          0: begin
            send_word(ActTimeout, ByteW'($urandom), 1'b1);
            return;
          end
          1: begin
            b = ByteW'($urandom);
            if (b == ChStx) b = ~b;
            send_word(ActByte, b, 1'b1);
            return;
          end
          2: begin
            send_word(ActStart, ByteW'($urandom), 1'b1);
            return;
          end
          default: ;
        endcase
        send_word(ActByte, ChStx, 1'b1);
        sum = '0;
        for (int i = 0; i < size; i++) begin
          if ($urandom_range(499) == 0) begin
            send_word(ActTimeout, ByteW'($urandom), 1'b1);
            return;
          end
          b   = ByteW'($urandom);
          sum = sum + b;
          send_word(ActByte, b, 1'b1);
        end
        // A wrong terminator is often the other one.
        if ($urandom_range(49) == 0) begin
          b = $urandom_range(1) ? ((term == ChEtx) ? ChEtb : ChEtx) : ByteW'($urandom);
          if (b == term) b = b ^ 8'h80;
          send_word(ActByte, b, 1'b1);
          return;
        end
        send_word(ActByte, term, 1'b1);
        if ($urandom_range(99) < nak_pct) begin
          send_word(ActByte, sum ^ ByteW'($urandom_range(1, 255)), 1'b1);
          naks++;
          if (naks > cur_retry) return;
        end else begin
          send_word(ActByte, sum, 1'b1);
          break;
        end
      end
    end
    // Closing EOT, sometimes missing or wrong.
    case ($urandom_range(19))
      0: send_word(ActTimeout, ByteW'($urandom), 1'b1);
      1: begin
        b = ByteW'($urandom);
        if (b == ChEot) b = ~b;
        send_word(ActByte, b, 1'b1);
      end
      default: send_word(ActByte, ChEot, 1'b1);
    endcase
  endtask

  // Stimulus and final verdict.
  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.action  = ActStart;
    in_if.rx_byte = '0;
    out_if.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Words that arrive while idle are ignored.
    send_word(ActByte, 8'h00, 1'b0);
    send_word(ActUnused, 8'hFF, 1'b0);
    send_word(ActTimeout, 8'hA5, 1'b0);
    drain_results();
    reg_write(RegRetryLimit, 32'd0);
    reg_write(RegByteCount, 32'd0);

    // Single byte with a bad LRC and no retries allowed: NAK and abort.
    send_word(ActStart, 8'h00, 1'b1);
    send_word(ActByte, ChStx, 1'b1);
    send_word(ActByte, 8'hFF, 1'b1);
    send_word(ActByte, ChEtx, 1'b1);
    send_word(ActByte, 8'h00, 1'b1);
    // Missing STX.
    send_word(ActStart, 8'hFF, 1'b1);
    send_word(ActByte, 8'h00, 1'b1);
    // ETB where ETX belongs.
    send_word(ActStart, 8'h00, 1'b1);
    send_word(ActByte, ChStx, 1'b1);
    send_word(ActByte, 8'h80, 1'b1);
    send_word(ActByte, ChEtb, 1'b1);
    // Good block, then a wrong byte in place of the final EOT.
    send_word(ActStart, 8'h00, 1'b1);
    send_word(ActByte, ChStx, 1'b1);
    send_word(ActByte, 8'h01, 1'b1);
    send_word(ActByte, ChEtx, 1'b1);
    send_word(ActByte, 8'h01, 1'b1);
    send_word(ActByte, 8'h00, 1'b1);
    // Restart while busy, then a timeout.
    send_word(ActStart, 8'h00, 1'b1);
    send_word(ActByte, ChStx, 1'b1);
    send_word(ActStart, 8'h00, 1'b1);
    send_word(ActTimeout, 8'h00, 1'b1);
    // The byte count shrinks in the middle of a block; the next data byte ends the block.
    drain_results();
    reg_write(RegByteCount, 32'd200);
    send_word(ActStart, 8'h00, 1'b1);
    send_word(ActByte, ChStx, 1'b1);
    send_word(ActByte, 8'h10, 1'b1);
    send_word(ActByte, 8'h20, 1'b1);
    send_word(ActByte, 8'h30, 1'b1);
    drain_results();
    reg_write(RegByteCount, 32'd2);
    send_word(ActByte, 8'h40, 1'b1);
    send_word(ActByte, ChEtx, 1'b1);
    send_word(ActByte, 8'hA0, 1'b1);
    send_word(ActByte, ChEot, 1'b1);

    // Random transfers under each idle and stall mix.
    for (int p = 0; p < 4; p++) begin
      int unsigned target;
      drain_results();
      idle_pct  = src_mix[p];
      stall_pct = snk_mix[p];
      if (p == 0) begin
        // Largest count and retry limit: one full block, then a timeout.
        reg_write(RegRetryLimit, 32'((1 << RetryW) - 1));
        reg_write(RegByteCount, 32'((1 << CountW) - 1));
        run_transfer(1);
        drain_results();
      end
      pick_config();
      target = n_items + 50;
      while (n_items < target) begin
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_word(ActionW'($urandom_range(ActByte, ActUnused)), ByteW'($urandom), 1'b0);
          end
        end
        run_transfer(-1);
        if ($urandom_range(3) == 0) begin
          drain_results();
          pick_config();
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    n_fail = rx_pred.close_out();
    $display("Drove %0d words (%0d in transfers) over four idle/stall mixes with %0d register writes.",
             n_words, n_items, n_cfg);
    $display("Checked %0d results; transfers ended clean %0d, timeout %0d, framing %0d, retry %0d, no EOT %0d.",
             rx_pred.n_checked, rx_pred.ends_by_code[ErrNone], rx_pred.ends_by_code[ErrTimeout],
             rx_pred.ends_by_code[ErrNoStx] + rx_pred.ends_by_code[ErrNoEtb] +
             rx_pred.ends_by_code[ErrNoEtx], rx_pred.ends_by_code[ErrRetry],
             rx_pred.ends_by_code[ErrNoEot]);
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d failures", n_fail);
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #5_000_000;
    $display("Run stopped by the time limit");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/blrc_pkg.sv
rtl/core/blrc_if.sv
rtl/core/blrc_cfg.sv
rtl/core/blrc_fsm.sv
rtl/core/block_receiver_lrc_ack_nak.sv
bench/block_receiver_lrc_ack_nak_tb.sv
